>>> rtl/npcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcs_pkg: shared types and constants for the nearest palette colour search
// Palette geometry, distance widths, field codes and the channel distance
// helper used by the distance unit.
// ----------------------------------------------------------------------------
package npcs_pkg;

  // palette geometry
  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);

  // field widths from the channel definitions
  localparam int COLOR_W     = 32;
  localparam int ENTRY_IDX_W = 8;
  localparam int OUT_IDX_W   = 8;
  localparam int ALPHA_W     = 8;
  localparam int COUNT_W     = 9;
  localparam int CFG_IDX_W   = 2;

  // distance: four squared 8-bit differences fit in 18 bits
  localparam int SQ_W   = 16;
  localparam int DIST_W = SQ_W + 2;
  localparam logic [DIST_W-1:0] DIST_LIMIT = DIST_W'(32767);

  // skip of entry zero needs more than this many entries in use
  localparam int START_MIN_COUNT = 2;

  // word kinds on the input channel
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENCY_ON   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COUNT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT_COLOR = 2'd3;

  // reset values of the configuration registers
  localparam logic [ALPHA_W-1:0] ALPHA_THRESHOLD_RST   = 8'd15;
  localparam logic               TRANSPARENCY_ON_RST   = 1'b0;
  localparam logic [COUNT_W-1:0] PALETTE_COUNT_RST     = 9'd256;
  localparam logic [COLOR_W-1:0] TRANSPARENT_COLOR_RST = 32'h00FF_FFFF;

  // one candidate leaving the distance unit
  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] dist_sq;
  } cand_t;

  // squared difference of two 8-bit channels
  function automatic logic [SQ_W-1:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    begin
      d = (a >= b) ? (a - b) : (b - a);
      sq_diff = SQ_W'(d) * SQ_W'(d);
    end
  endfunction

endpackage

>>> rtl/npcs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcs channels: input word and result word interfaces
// Valid/ready channels with source and sink views; a word moves on a clock
// edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface npcs_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic [npcs_pkg::ENTRY_IDX_W-1:0]    entry_index;
  logic [npcs_pkg::COLOR_W-1:0]        entry_color;
  logic [npcs_pkg::COLOR_W-1:0]        pixel_color;

  modport source (output valid, mode, entry_index, entry_color, pixel_color, input ready);
  modport sink   (input valid, mode, entry_index, entry_color, pixel_color, output ready);
endinterface

interface npcs_out_if;
  logic                             valid;
  logic                             ready;
  logic [npcs_pkg::OUT_IDX_W-1:0]   palette_index;

  modport source (output valid, palette_index, input ready);
  modport sink   (input valid, palette_index, output ready);
endinterface

>>> rtl/npcs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined until
// written.
// ----------------------------------------------------------------------------
module npcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/npcs_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcs_dist: shared squared-distance unit
// Takes one palette entry per cycle against the held query colour and
// registers the sum of squared ARGB channel differences with its index.
// ----------------------------------------------------------------------------
module npcs_dist (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          entry_valid,
  input  logic [npcs_pkg::IDX_W-1:0]    entry_idx,
  input  logic [npcs_pkg::COLOR_W-1:0]  entry_color,
  input  logic [npcs_pkg::COLOR_W-1:0]  query_color,
  output npcs_pkg::cand_t               cand
);

  logic [npcs_pkg::SQ_W-1:0]   sq_a;
  logic [npcs_pkg::SQ_W-1:0]   sq_r;
  logic [npcs_pkg::SQ_W-1:0]   sq_g;
  logic [npcs_pkg::SQ_W-1:0]   sq_b;
  logic [npcs_pkg::DIST_W-1:0] dist_next;

  // per-channel squares and their sum
  always_comb begin
    sq_a = npcs_pkg::sq_diff(entry_color[31:24], query_color[31:24]);
    sq_r = npcs_pkg::sq_diff(entry_color[23:16], query_color[23:16]);
    sq_g = npcs_pkg::sq_diff(entry_color[15:8],  query_color[15:8]);
    sq_b = npcs_pkg::sq_diff(entry_color[7:0],   query_color[7:0]);
    dist_next = npcs_pkg::DIST_W'(sq_a) + npcs_pkg::DIST_W'(sq_r)
              + npcs_pkg::DIST_W'(sq_g) + npcs_pkg::DIST_W'(sq_b);
  end

  // candidate register
  always_ff @(posedge clk) begin
    if (rst) begin
      cand.valid <= 1'b0;
    end else begin
      cand.valid <= entry_valid;
    end
    cand.idx     <= entry_idx;
    cand.dist_sq <= dist_next;
  end

endmodule

>>> rtl/nearest_palette_color_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_search: nearest ARGB palette entry by squared distance
// Palette load words and query words share one input channel; each query
// gives one palette index on the result channel.
// ----------------------------------------------------------------------------
// A load word (mode 0) writes one palette entry and gives no result. A query
// word (mode 1) is searched against entries start..n-1, one entry per cycle
// through a single shared distance unit fed from the palette RAM, where n is
// palette_count clamped to the palette depth and start is 0 or 1. Each entry
// passes the RAM read, the distance register and the compare in that order;
// the input is not ready while a query is searched. The result sits in an
// output register, so the next word is taken while it waits. The user must
// write configuration only while the block is idle; the block does not
// enforce this.
// ----------------------------------------------------------------------------
module nearest_palette_color_search (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [npcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [npcs_pkg::COLOR_W-1:0]       cfg_data,
  npcs_in_if.sink                            item,
  npcs_out_if.source                         result
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;

  // configuration registers
  logic [npcs_pkg::ALPHA_W-1:0] alpha_threshold;
  logic                         transparency_on;
  logic [npcs_pkg::COUNT_W-1:0] palette_count;
  logic [npcs_pkg::COLOR_W-1:0] transparent_color;

  // sequencer and search state
  logic [1:0]                    state;
  logic [npcs_pkg::CNT_W-1:0]    addr;
  logic [npcs_pkg::CNT_W-1:0]    n_lim;
  logic [npcs_pkg::COLOR_W-1:0]  query;
  logic [npcs_pkg::DIST_W-1:0]   best_dist;
  logic [npcs_pkg::IDX_W-1:0]    best_idx;
  logic                          s1_valid;
  logic [npcs_pkg::IDX_W-1:0]    s1_idx;
  logic                          out_valid;
  logic [npcs_pkg::OUT_IDX_W-1:0] out_index;

  logic                          accept;
  logic                          load_we;
  logic                          rd_en;
  logic [npcs_pkg::COLOR_W-1:0]  rd_data;
  logic [npcs_pkg::COLOR_W-1:0]  pick_color;
  logic [npcs_pkg::CNT_W-1:0]    n_next;
  logic                          start_one;
  npcs_pkg::cand_t               cand;

  // handshakes
  assign item.ready    = (state == ST_IDLE);
  assign accept        = item.valid && item.ready;
  assign result.valid  = out_valid;
  assign result.palette_index = out_index;

  // load words in range write the palette
  assign load_we = accept && (item.mode == npcs_pkg::MODE_LOAD)
                && (32'(item.entry_index) < 32'(npcs_pkg::PALETTE_DEPTH));

  // query set-up: stand-in colour, clamped count, start entry
  always_comb begin
    pick_color = (item.pixel_color[31:24] <= alpha_threshold) ? transparent_color
                                                              : item.pixel_color;
    n_next = (32'(palette_count) > 32'(npcs_pkg::PALETTE_DEPTH))
           ? npcs_pkg::CNT_W'(npcs_pkg::PALETTE_DEPTH)
           : npcs_pkg::CNT_W'(palette_count);
    start_one = (32'(n_next) > 32'(npcs_pkg::START_MIN_COUNT)) && transparency_on
             && (pick_color[31:24] > alpha_threshold);
  end

  // one palette read per cycle while entries remain
  assign rd_en = (state == ST_SEARCH) && (addr < n_lim);

  npcs_ram #(
    .WIDTH (npcs_pkg::COLOR_W),
    .DEPTH (npcs_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .wr_en   (load_we),
    .wr_addr (npcs_pkg::IDX_W'(item.entry_index)),
    .wr_data (item.entry_color),
    .rd_en   (rd_en),
    .rd_addr (addr[npcs_pkg::IDX_W-1:0]),
    .rd_data (rd_data)
  );

  npcs_dist u_dist (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (s1_valid),
    .entry_idx   (s1_idx),
    .entry_color (rd_data),
    .query_color (query),
    .cand        (cand)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_threshold   <= npcs_pkg::ALPHA_THRESHOLD_RST;
      transparency_on   <= npcs_pkg::TRANSPARENCY_ON_RST;
      palette_count     <= npcs_pkg::PALETTE_COUNT_RST;
      transparent_color <= npcs_pkg::TRANSPARENT_COLOR_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        npcs_pkg::CFG_ALPHA_THRESHOLD:   alpha_threshold   <= cfg_data[npcs_pkg::ALPHA_W-1:0];
        npcs_pkg::CFG_TRANSPARENCY_ON:   transparency_on   <= cfg_data[0];
        npcs_pkg::CFG_PALETTE_COUNT:     palette_count     <= cfg_data[npcs_pkg::COUNT_W-1:0];
        npcs_pkg::CFG_TRANSPARENT_COLOR: transparent_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // read stage tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= rd_en;
    end
    s1_idx <= addr[npcs_pkg::IDX_W-1:0];
  end

  // sequencer, running minimum and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      addr      <= '0;
      n_lim     <= '0;
    end else begin
      // the done state sets or holds the result word itself
      if (result.ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (item.mode == npcs_pkg::MODE_QUERY)) begin
            state     <= ST_SEARCH;
            query     <= pick_color;
            n_lim     <= n_next;
            addr      <= npcs_pkg::CNT_W'(start_one);
            best_idx  <= npcs_pkg::IDX_W'(start_one);
            best_dist <= npcs_pkg::DIST_LIMIT;
          end
        end
        ST_SEARCH: begin
          if (rd_en) begin
            addr <= npcs_pkg::CNT_W'(addr + 1'b1);
          end
          // later index wins a tie
          if (cand.valid && (cand.dist_sq <= best_dist)) begin
            best_dist <= cand.dist_sq;
            best_idx  <= cand.idx;
          end
          if (!rd_en && !s1_valid && !cand.valid) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_index <= npcs_pkg::OUT_IDX_W'(best_idx);
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // running minimum never rises above the acceptance limit
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (best_dist <= npcs_pkg::DIST_LIMIT))
    else $error("best distance above limit");

  // palette reads stay inside the clamped count
  assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (addr < n_lim) && (32'(n_lim) <= 32'(npcs_pkg::PALETTE_DEPTH)))
    else $error("palette read beyond count");

  // the pipeline is empty once the search has finished
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (!s1_valid && !cand.valid))
    else $error("search ended with entries in flight");

  // an accepted query starts a search on the next edge
  assert property (@(posedge clk) disable iff (rst)
    (accept && (item.mode == npcs_pkg::MODE_QUERY)) |=> (state == ST_SEARCH))
    else $error("query did not start a search");

endmodule
